// ===== hdl/ntwa_pkg.sv =====
// ----------------------------------------------------------------------------
// ntwa_pkg
// Shared types and constants for the neighbor table with aging.
// ----------------------------------------------------------------------------
package ntwa_pkg;

  localparam int TABLE_DEPTH_DEF = 32;
  localparam logic [31:0] INACTIVE_AFTER_RST = 32'd60000;

  localparam logic OP_OBSERVE = 1'b0;
  localparam logic OP_CLOSE   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN_OBS,
    ST_SCAN_AGE
  } state_t;

  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
    logic [31:0] last_seen;
  } entry_t;

endpackage

// ===== hdl/neighbor_table_with_aging.sv =====
// ----------------------------------------------------------------------------
// neighbor_table_with_aging
// Host table in one synchronous memory: linear ip lookup with update or
// append on observe, aging sweep with seen-flag clear on close pass.
// ----------------------------------------------------------------------------
// a hit ends the scan at its entry, while a miss or a close pass walks every stored
//   entry; the scan covers one stored entry per cycle
// throughput: one item at a time, the next start is taken in the strobe cycle
// reset clears the fill count and the active and seen flags at once, no sweep
// results show for one cycle only, the receiver cannot stall them
module neighbor_table_with_aging #(
  parameter int TABLE_DEPTH = ntwa_pkg::TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        opcode,
  input  logic [31:0] ip_addr,
  input  logic [47:0] mac_addr,
  input  logic [31:0] now_ms,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  output logic        result_valid,
  output logic [4:0]  entry_index,
  output logic        matched,
  output logic        inserted,
  output logic        table_full,
  output logic        changed,
  output logic [5:0]  deactivated_count
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  ntwa_pkg::state_t state, state_next;

  logic [31:0] inactive_after;
  logic [31:0] ip_q, now_q;
  logic [47:0] mac_q;

  logic [CW-1:0] ptr, ptr_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] deact, deact_next;
  logic          cmp_vld, cmp_vld_next;
  logic [IW-1:0] cmp_idx, cmp_idx_next;
  logic [TABLE_DEPTH-1:0] active, active_next;
  logic [TABLE_DEPTH-1:0] seen, seen_next;

  ntwa_pkg::entry_t mem [TABLE_DEPTH];
  ntwa_pkg::entry_t rd_data, wdata;
  logic [IW-1:0]    waddr;
  logic             we;

  logic          res_valid_next, res_matched_next, res_inserted_next;
  logic          res_full_next, res_changed_next;
  logic [IW-1:0] res_idx_next;
  logic [CW-1:0] res_deact_next;
  logic [IW+4:0] idx_ext;
  logic [CW+5:0] deact_ext;

  logic        ip_hit, age_hit, room;
  logic [31:0] age;

  assign busy      = (state != ntwa_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

  assign ip_hit = cmp_vld && (rd_data.ip == ip_q);
  assign age    = now_q - rd_data.last_seen;
  assign age_hit = cmp_vld && active[cmp_idx] && !seen[cmp_idx] && (age > inactive_after);
  assign room   = (count != CW'(TABLE_DEPTH));

  // entry memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data <= mem[ptr[IW-1:0]];
  end

  always_comb begin
    state_next        = state;
    ptr_next          = ptr;
    count_next        = count;
    deact_next        = deact;
    cmp_vld_next      = 1'b0;
    cmp_idx_next      = cmp_idx;
    active_next       = active;
    seen_next         = seen;
    we                = 1'b0;
    waddr             = cmp_idx;
    wdata             = '{ip: ip_q, mac: mac_q, last_seen: now_q};
    res_valid_next    = 1'b0;
    res_matched_next  = 1'b0;
    res_inserted_next = 1'b0;
    res_full_next     = 1'b0;
    res_changed_next  = 1'b0;
    res_idx_next      = '0;
    res_deact_next    = '0;
    unique case (state)
      ntwa_pkg::ST_IDLE: begin
        if (start) begin
          ptr_next   = '0;
          deact_next = '0;
          state_next = (opcode == ntwa_pkg::OP_CLOSE) ? ntwa_pkg::ST_SCAN_AGE
                                                      : ntwa_pkg::ST_SCAN_OBS;
        end
      end
      ntwa_pkg::ST_SCAN_OBS: begin
        if (ip_hit) begin
          we                   = 1'b1;
          waddr                = cmp_idx;
          active_next[cmp_idx] = 1'b1;
          seen_next[cmp_idx]   = 1'b1;
          res_valid_next       = 1'b1;
          res_matched_next     = 1'b1;
          res_changed_next     = !active[cmp_idx] || (rd_data.mac != mac_q);
          res_idx_next         = cmp_idx;
          state_next           = ntwa_pkg::ST_IDLE;
        end else if (ptr < count) begin
          cmp_vld_next = 1'b1;
          cmp_idx_next = ptr[IW-1:0];
          ptr_next     = ptr + 1'b1;
        end else begin
          // miss: append or report full
          res_valid_next = 1'b1;
          state_next     = ntwa_pkg::ST_IDLE;
          if (room) begin
            we                          = 1'b1;
            waddr                       = count[IW-1:0];
            active_next[count[IW-1:0]]  = 1'b1;
            seen_next[count[IW-1:0]]    = 1'b1;
            count_next                  = count + 1'b1;
            res_inserted_next           = 1'b1;
            res_changed_next            = 1'b1;
            res_idx_next                = count[IW-1:0];
          end else begin
            res_full_next = 1'b1;
          end
        end
      end
      ntwa_pkg::ST_SCAN_AGE: begin
        if (age_hit) begin
          active_next[cmp_idx] = 1'b0;
          deact_next           = deact + 1'b1;
        end
        if (ptr < count) begin
          cmp_vld_next = 1'b1;
          cmp_idx_next = ptr[IW-1:0];
          ptr_next     = ptr + 1'b1;
        end else begin
          seen_next        = '0;
          res_valid_next   = 1'b1;
          res_deact_next   = deact_next;
          res_changed_next = (deact_next != '0);
          state_next       = ntwa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ntwa_pkg::ST_IDLE;
      end
    endcase
  end

  assign idx_ext   = {5'b0, res_idx_next};
  assign deact_ext = {6'b0, res_deact_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ntwa_pkg::ST_IDLE;
      inactive_after <= ntwa_pkg::INACTIVE_AFTER_RST;
      count          <= '0;
      active         <= '0;
      seen           <= '0;
      cmp_vld        <= 1'b0;
      result_valid   <= 1'b0;
    end else begin
      state        <= state_next;
      count        <= count_next;
      active       <= active_next;
      seen         <= seen_next;
      cmp_vld      <= cmp_vld_next;
      result_valid <= res_valid_next;
      if (cfg_valid && cfg_ready) begin
        inactive_after <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr     <= ptr_next;
    deact   <= deact_next;
    cmp_idx <= cmp_idx_next;
    if (start && !busy) begin
      ip_q  <= ip_addr;
      mac_q <= mac_addr;
      now_q <= now_ms;
    end
    entry_index       <= idx_ext[4:0];
    matched           <= res_matched_next;
    inserted          <= res_inserted_next;
    table_full        <= res_full_next;
    changed           <= res_changed_next;
    deactivated_count <= deact_ext[5:0];
  end

endmodule

// ===== hdl/ntwa_checker.sv =====
// ----------------------------------------------------------------------------
// ntwa_checker
// Port-level checks of the neighbor table, bound to the top level.
// ----------------------------------------------------------------------------
module ntwa_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       result_valid,
  input logic       matched,
  input logic       inserted,
  input logic       table_full,
  input logic       changed,
  input logic [5:0] deactivated_count
);

  // an accepted beat keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy low after accepted beat");

  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe held for two cycles");

  a_kind_excl: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !((matched && inserted) || (matched && table_full) ||
                       (inserted && table_full)))
    else $error("conflicting result kinds");

  a_full_quiet: assert property (@(posedge clk) disable iff (rst)
    (result_valid && table_full) |-> (!changed && deactivated_count == 6'd0))
    else $error("full result reports a change");

  a_deact_changed: assert property (@(posedge clk) disable iff (rst)
    (result_valid && deactivated_count != 6'd0) |-> (changed && !matched && !inserted))
    else $error("aging result inconsistent");

endmodule

bind neighbor_table_with_aging ntwa_checker u_ntwa_checker (
  .clk               (clk),
  .rst               (rst),
  .start             (start),
  .busy              (busy),
  .result_valid      (result_valid),
  .matched           (matched),
  .inserted          (inserted),
  .table_full        (table_full),
  .changed           (changed),
  .deactivated_count (deactivated_count)
);
